@@ hdl/mhpq_pkg.sv @@
// Package for the max-heap priority queue core.
// Holds sizes, operation and status codes, and the structs shared by the cell row,
// the output buffer and the top level. No dependencies.
package mhpq_pkg;

  // Number of entries the queue can hold.
  localparam int unsigned CAPACITY = 128;
  // Width of a stored value.
  localparam int unsigned DATA_W   = 32;
  // Width of the entry count, wide enough to hold CAPACITY itself.
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Operation selector carried on the input tuser.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status carried on the output tuser.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Control broadcast to every cell of the sorted row.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  // Result data, removed value in the lowest bits.
  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic        [CNT_W-1:0]  entry_count;
    logic signed [DATA_W-1:0] removed_value;
  } result_t;

  // One complete result item as held in the output buffer.
  typedef struct packed {
    status_e status;
    result_t data;
  } out_item_t;

endpackage

@@ hdl/max_heap_priority_queue_core.sv @@
// Top level of the max-heap priority queue core.
// Depends on mhpq_pkg, mhpq_cell and mhpq_out_buf.
//
// A priority queue of up to CAPACITY (128) signed 32-bit values. Each input item
// (tuser = command, tdata = value) either inserts its value or removes the largest
// entry, and yields exactly one registered result item: status on tuser, and
// on tdata the removed value, the entry count and the current largest value. The
// entries live in a row of cells kept in descending order; every item is done
// by one compare in each cell and a one-place shift of the row, so the core takes
// one item per cycle while the output buffer has room. The two-entry output buffer
// lets it take one more item once the result side stalls. An insert into a full
// queue reports overflow and a remove from an empty queue reports underflow;
// neither changes the contents. No clearing pass is needed after reset.
module max_heap_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tuser,   // [0] cmd
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] removed_value, [39:32] entry_count,
                                      // [71:40] top_value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned                 CAP = mhpq_pkg::CAPACITY;
  localparam logic [mhpq_pkg::CNT_W-1:0]  CAP_CNT = mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY);

  logic [mhpq_pkg::CNT_W-1:0]              count_q, count_d;
  logic                                    accept;
  logic                                    full, empty;
  logic                                    do_ins, do_rem;
  mhpq_pkg::cell_ctrl_t                    ctrl;
  mhpq_pkg::out_item_t                     result;
  mhpq_pkg::out_item_t                     out_item;
  logic signed [mhpq_pkg::DATA_W-1:0]      cell_val [CAP];
  logic [CAP-1:0]                          cell_valid;
  logic [CAP-1:0]                          cell_ge;
  logic                                    buf_ready;

  // Handshake and decode of the command.
  assign s_axis_tready = buf_ready;
  assign accept        = s_axis_tvalid && buf_ready;
  assign full          = (count_q == CAP_CNT);
  assign empty         = (count_q == '0);
  assign do_ins        = accept && (s_axis_tuser == mhpq_pkg::CMD_INSERT) && !full;
  assign do_rem        = accept && (s_axis_tuser == mhpq_pkg::CMD_REMOVE) && !empty;

  assign ctrl.ins   = do_ins;
  assign ctrl.rem   = do_rem;
  assign ctrl.value = $signed(s_axis_tdata);

  // Row of sorted cells, largest value in cell zero.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic                               prev_ge, prev_valid, next_valid;
    logic signed [mhpq_pkg::DATA_W-1:0] prev_val, next_val;

    if (i == 0) begin : g_first
      assign prev_ge    = 1'b1;
      assign prev_valid = 1'b0;
      assign prev_val   = '0;
    end else begin : g_inner
      assign prev_ge    = cell_ge[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_val   = cell_val[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_val   = '0;
    end else begin : g_body
      assign next_valid = cell_valid[i+1];
      assign next_val   = cell_val[i+1];
    end

    mhpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_ge_i    (prev_ge),
      .prev_valid_i (prev_valid),
      .prev_val_i   (prev_val),
      .next_valid_i (next_valid),
      .next_val_i   (next_val),
      .ge_o         (cell_ge[i]),
      .valid_o      (cell_valid[i]),
      .val_o        (cell_val[i])
    );
  end

  // Entry count.
  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + mhpq_pkg::CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - mhpq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Build the result item from the row as it stands after this step.
  always_comb begin
    result.status             = mhpq_pkg::ST_DONE;
    result.data.removed_value = '0;
    result.data.entry_count   = count_d;
    result.data.top_value     = cell_valid[0] ? cell_val[0] : '0;
    if (do_ins) begin
      result.data.top_value = cell_ge[0] ? cell_val[0] : ctrl.value;
    end else if (do_rem) begin
      result.data.removed_value = cell_val[0];
      result.data.top_value     = cell_valid[1] ? cell_val[1] : '0;
    end else if (s_axis_tuser == mhpq_pkg::CMD_INSERT) begin
      result.status = mhpq_pkg::ST_OVERFLOW;
    end else begin
      result.status = mhpq_pkg::ST_UNDERFLOW;
    end
  end

  mhpq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_item_i   (result),
    .in_ready_o  (buf_ready),
    .out_valid_o (m_axis_tvalid),
    .out_item_o  (out_item),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = out_item.data;
  assign m_axis_tuser = out_item.status;

  // The count always equals the number of occupied cells.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("entry count does not match occupied cells");

  // Occupied cells form an unbroken run starting at cell zero.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + CAP'(1))) == '0)
    else $error("gap in the occupied cells");

  // The front cell holds a value no smaller than the second cell.
  a_front_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> (cell_val[0] >= cell_val[1]))
    else $error("front cell is not the largest entry");

  // An accepted insert into a full queue leaves the count unchanged.
  a_overflow_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (s_axis_tuser == mhpq_pkg::CMD_INSERT)) |=> (count_q == CAP_CNT))
    else $error("refused insert changed the count");

endmodule

@@ hdl/mhpq_cell.sv @@
// One cell of the sorted row: holds a single value and its valid flag.
// Depends on mhpq_pkg for the control struct and data width.
module mhpq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mhpq_pkg::cell_ctrl_t              ctrl_i,
  input  logic                              prev_ge_i,
  input  logic                              prev_valid_i,
  input  logic signed [mhpq_pkg::DATA_W-1:0] prev_val_i,
  input  logic                              next_valid_i,
  input  logic signed [mhpq_pkg::DATA_W-1:0] next_val_i,
  output logic                              ge_o,
  output logic                              valid_o,
  output logic signed [mhpq_pkg::DATA_W-1:0] val_o
);

  logic                              valid_q, valid_d;
  logic signed [mhpq_pkg::DATA_W-1:0] val_q, val_d;

  // This cell keeps its place on an insert when it holds a value at least as large.
  assign ge_o = valid_q && ($signed(val_q) >= $signed(ctrl_i.value));

  // Insert shifts the tail right by one and drops the new value into the gap;
  // remove shifts the whole row left by one.
  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    if (ctrl_i.ins && !ge_o) begin
      if (prev_ge_i) begin
        valid_d = 1'b1;
        val_d   = ctrl_i.value;
      end else begin
        valid_d = prev_valid_i;
        val_d   = prev_val_i;
      end
    end else if (ctrl_i.rem) begin
      valid_d = next_valid_i;
      val_d   = next_val_i;
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stored value.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;

endmodule

@@ hdl/mhpq_out_buf.sv @@
// Output register with a skid stage for result items.
// Depends on mhpq_pkg for the result item struct.
module mhpq_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  mhpq_pkg::out_item_t  in_item_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output mhpq_pkg::out_item_t  out_item_o,
  input  logic                 out_ready_i
);

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  mhpq_pkg::out_item_t out_item_q, out_item_d;
  mhpq_pkg::out_item_t skid_item_q, skid_item_d;
  logic                push;
  logic                slot_free;

  // The skid stage absorbs one item while the output register is stalled.
  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Move items forward: skid first, then a new item.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    skid_valid_d = skid_valid_q;
    skid_item_d  = skid_item_q;
    if (slot_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_item_d   = skid_item_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_item_d  = in_item_i;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_item_d  = in_item_i;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_item_q  <= out_item_d;
    skid_item_q <= skid_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ verif/mhpq_checker.sv @@
// Checker for the max-heap priority queue core: watches both item channels,
// predicts each result with its own heap and compares it with the block.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel as seen at the block.
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] in_data_i,
  input  logic        in_user_i,
  // Result channel as seen at the block.
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [71:0] out_data_i,
  input  logic [1:0]  out_user_i,
  // Failures so far and results still owed by the block.
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Shadow heap and the results it has promised.
  logic signed [mhpq_pkg::DATA_W-1:0] heap_q [mhpq_pkg::CAPACITY];
  int unsigned                        heap_fill;
  mhpq_pkg::out_item_t                owed_q [$];
  int unsigned                        failures;

  // Apply one command to the shadow heap and return the result it must give.
  function automatic mhpq_pkg::out_item_t heap_apply(logic cmd,
                                                     logic signed [31:0] value);
    mhpq_pkg::out_item_t                res;
    int unsigned                        pos;
    int unsigned                        parent;
    int unsigned                        pick;
    int unsigned                        child;
    logic signed [mhpq_pkg::DATA_W-1:0] swap_v;
    bit                                 settled;
    res        = '0;
    res.status = mhpq_pkg::ST_DONE;
    if (cmd == mhpq_pkg::CMD_INSERT) begin
      if (heap_fill >= mhpq_pkg::CAPACITY) begin
        res.status = mhpq_pkg::ST_OVERFLOW;
      end else begin
        // Append, then move up while the parent is strictly smaller.
        heap_q[heap_fill] = value;
        pos     = heap_fill;
        settled = 1'b0;
        while (pos > 0 && !settled) begin
          parent = (pos - 1) / 2;
          if (heap_q[parent] < heap_q[pos]) begin
            swap_v         = heap_q[parent];
            heap_q[parent] = heap_q[pos];
            heap_q[pos]    = swap_v;
            pos            = parent;
          end else begin
            settled = 1'b1;
          end
        end
        heap_fill++;
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = mhpq_pkg::ST_UNDERFLOW;
      end else begin
        // Take the root, move the last entry up there and sink it.
        res.data.removed_value = heap_q[0];
        heap_q[0] = heap_q[heap_fill - 1];
        heap_fill--;
        pos     = 0;
        settled = 1'b0;
        while (!settled) begin
          pick  = pos;
          child = 2 * pos + 1;
          if (child < heap_fill && heap_q[pick] < heap_q[child]) pick = child;
          child = 2 * pos + 2;
          if (child < heap_fill && heap_q[pick] < heap_q[child]) pick = child;
          if (pick == pos) begin
            settled = 1'b1;
          end else begin
            swap_v       = heap_q[pos];
            heap_q[pos]  = heap_q[pick];
            heap_q[pick] = swap_v;
            pos          = pick;
          end
        end
      end
    end
    res.data.entry_count = heap_fill[mhpq_pkg::CNT_W-1:0];
    res.data.top_value   = (heap_fill > 0) ? heap_q[0] : '0;
    return res;
  endfunction

  // Predict on every accepted input item, compare on every accepted result item.
  always @(posedge clk_i or negedge rst_ni) begin
    mhpq_pkg::out_item_t want;
    mhpq_pkg::out_item_t got;
    if (!rst_ni) begin
      heap_fill = 0;
      failures  = 0;
      owed_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        owed_q.push_back(heap_apply(in_user_i, in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = {out_user_i, out_data_i};
        if (owed_q.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: unexpected result: status %0d removed %0d count %0d top %0d",
                     $realtime, got.status, got.data.removed_value,
                     got.data.entry_count, got.data.top_value);
          end
        end else begin
          want = owed_q.pop_front();
          if (got.status != want.status ||
              got.data.removed_value != want.data.removed_value ||
              got.data.entry_count != want.data.entry_count ||
              got.data.top_value != want.data.top_value) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: mismatch status exp %0d got %0d, removed exp %0d got %0d",
                       $realtime, want.status, got.status,
                       want.data.removed_value, got.data.removed_value);
              $display("          count exp %0d got %0d, top exp %0d got %0d",
                       want.data.entry_count, got.data.entry_count,
                       want.data.top_value, got.data.top_value);
            end
          end
        end
      end
      fail_count_o <= failures;
      pending_o    <= owed_q.size();
    end
  end

endmodule

@@ verif/tb_max_heap_priority_queue_core.sv @@
// Testbench top for the max-heap priority queue core: drives commands with random
// gaps and result stalls, and gives the verdict from the checker's failure count.
// Depends on mhpq_pkg, mhpq_checker and max_heap_priority_queue_core.
`timescale 1ns / 1ps

module tb_max_heap_priority_queue_core;

  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = mhpq_pkg::CMD_INSERT;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle;
  int unsigned recv_stall;
  int unsigned level;
  int unsigned quiet_cycles;

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  max_heap_priority_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mhpq_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side: stall at random at the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Watchdog: give up after a long stretch with no item moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** max_heap_priority_queue_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_item(logic cmd, logic [31:0] value);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    // Track the fill level to steer the random walk.
    if (cmd == mhpq_pkg::CMD_INSERT && level < mhpq_pkg::CAPACITY) level++;
    else if (cmd == mhpq_pkg::CMD_REMOVE && level > 0) level--;
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mix of extremes, small values that collide often, and full-range words.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2, 3:    v = int'($urandom_range(16)) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Fill to capacity, knock on the full queue, then empty it again.
  task automatic fill_and_drain();
    int k;
    while (level < mhpq_pkg::CAPACITY) send_item(mhpq_pkg::CMD_INSERT, pick_value());
    for (k = 0; k < 3; k++) send_item(mhpq_pkg::CMD_INSERT, pick_value());
    while (level > 0) send_item(mhpq_pkg::CMD_REMOVE, $urandom);
    send_item(mhpq_pkg::CMD_REMOVE, $urandom);
  endtask

  // Random walk of the fill level toward moving targets, with some noise.
  task automatic run_random(int n_items);
    int          k;
    int unsigned target;
    logic        cmd;
    target = level;
    for (k = 0; k < n_items; k++) begin
      if (level == target) begin
        case ($urandom_range(3))
          0:       target = mhpq_pkg::CAPACITY;
          1:       target = 0;
          default: target = $urandom_range(mhpq_pkg::CAPACITY);
        endcase
      end
      if ($urandom_range(3) == 0) cmd = 1'($urandom_range(1));
      else cmd = (target > level) ? mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_REMOVE;
      send_item(cmd, pick_value());
    end
  endtask

  initial begin
    int ph;
    level        = 0;
    send_idle    = 0;
    recv_stall   = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: underflow, extreme values, duplicates, drain past empty.
    send_item(mhpq_pkg::CMD_REMOVE, 32'h0000_0000);
    send_item(mhpq_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
    send_item(mhpq_pkg::CMD_INSERT, 32'h0000_0000);
    send_item(mhpq_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_item(mhpq_pkg::CMD_INSERT, 32'h8000_0000);
    send_item(mhpq_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_item(mhpq_pkg::CMD_INSERT, 32'h0000_0005);
    send_item(mhpq_pkg::CMD_INSERT, 32'h0000_0005);
    send_item(mhpq_pkg::CMD_INSERT, 32'hFFFF_FFFB);
    send_item(mhpq_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_item(mhpq_pkg::CMD_INSERT, 32'h0000_0001);
    repeat (10) send_item(mhpq_pkg::CMD_REMOVE, 32'hA5A5_A5A5);
    send_item(mhpq_pkg::CMD_INSERT, 32'h8000_0000);
    send_item(mhpq_pkg::CMD_REMOVE, 32'h0000_0000);

    // Random phases with different idle and stall rates.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 77; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 77; end
        default: begin send_idle = 36; recv_stall = 36; end
      endcase
      if (ph == 0) fill_and_drain();
      run_random(360);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** max_heap_priority_queue_core: PASSED **");
    end else begin
      $display("** max_heap_priority_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
